@@ rtl/mi3_pkg.sv @@
// Package for the 3x3 matrix inverse pipeline: widths, stage counts and the
// cofactor index tables. No dependencies.
package mi3_pkg;
	localparam int FRAC_BITS = 16;              // fraction bits of the fixed-point entries
	localparam int EW        = 32;              // entry width
	localparam int NE        = 9;               // entries per matrix
	localparam int PW        = 2 * EW;          // cofactor width
	localparam int DETW      = 3 * EW + 1;      // signed determinant width
	localparam int RW        = DETW - 1;        // determinant magnitude / remainder width
	localparam int QB        = EW;              // quotient bits, one per divider stage
	localparam int XW        = RW + QB;         // shifted numerator workspace
	localparam int DIV0      = 8;               // stage index of the overflow check
	localparam int LAST      = DIV0 + QB + 1;   // stage index of the output register
	localparam int IN_W      = NE * EW;
	localparam int OUT_W     = NE * EW;

	localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] NEG_MAX = {1'b1, {(EW-1){1'b0}}};

	// adj[k] = m[PA]*m[PB] - m[PC]*m[PD]
	localparam int PA [0:NE-1] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PB [0:NE-1] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PC [0:NE-1] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PD [0:NE-1] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
endpackage

@@ rtl/matrix_inverse_3x3_core.sv @@
// 3x3 matrix inverse by adjugate over determinant, fixed point, fully pipelined.
// Depends on mi3_pkg.
//
// channel | dir | handshake              | payload
// s       | in  | s_tvalid / s_tready    | s_tdata: a00..a22, 32 bits each
// m       | out | m_tvalid / m_tready    | m_tdata: r00..r22, m_tuser: singular
//
// One matrix enters per cycle while the output is not stalled. Stages: 6
// cofactor/determinant, one magnitude, one overflow-check, one restoring-divider
// stage per quotient bit for all nine lanes at once, one saturation stage.
// Each stage holds its word while the stage after it is full and stalled, so
// bubbles close up and nothing is lost or repeated.
// Reset clears only the stage valid bits.
module matrix_inverse_3x3_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mi3_pkg::IN_W-1:0]    s_tdata,  // a00,a01,a02,a10,a11,a12,a20,a21,a22
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mi3_pkg::OUT_W-1:0]   m_tdata,  // r00,r01,r02,r10,r11,r12,r20,r21,r22
	output logic                        m_tuser   // singular
);
	import mi3_pkg::*;

	logic [LAST:1]   v;
	logic [LAST+1:1] en;

	logic signed [EW-1:0]   m_s1 [0:NE-1];
	logic signed [PW-1:0]   pa_s2 [0:NE-1];
	logic signed [PW-1:0]   pc_s2 [0:NE-1];
	logic signed [EW-1:0]   mr_s2 [0:2];
	logic signed [PW-1:0]   adj_s3 [0:NE-1];
	logic signed [EW-1:0]   mr_s3 [0:2];
	logic signed [PW-1:0]   adj_s4 [0:NE-1];
	logic signed [PW-1:0]   ph_s4 [0:2];
	logic signed [PW:0]     pl_s4 [0:2];
	logic signed [PW-1:0]   adj_s5 [0:NE-1];
	logic signed [DETW-1:0] t_s5 [0:2];
	logic signed [PW-1:0]   adj_s6 [0:NE-1];
	logic signed [DETW-1:0] det_s6;
	logic [RW-1:0]          rem_s7 [0:NE-1];
	logic [QB-1:0]          nlo_s7 [0:NE-1];
	logic [NE-1:0]          neg_s7;
	logic [RW-1:0]          dmag_s7;
	logic                   sing_s7;

	// divider pipeline, index 0 is the overflow-check stage
	logic [RW-1:0] rem_d  [0:QB][0:NE-1];
	logic [QB-1:0] nlo_d  [0:QB][0:NE-1];
	logic [QB-1:0] q_d    [0:QB][0:NE-1];
	logic [NE-1:0] neg_d  [0:QB];
	logic [NE-1:0] ovf_d  [0:QB];
	logic [RW-1:0] dmag_d [0:QB];
	logic          sing_d [0:QB];

	logic [OUT_W-1:0] res_q;
	logic             sing_q;

	// stage enables: a stage loads when empty or when its word moves on
	always_comb begin
		en[LAST+1] = m_tready;
		for (int i = LAST; i >= 1; i--) begin
			en[i] = !v[i] || en[i+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v[LAST];
	assign m_tdata  = res_q;
	assign m_tuser  = sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= s_tvalid;
			for (int i = 2; i <= LAST; i++) begin
				if (en[i]) v[i] <= v[i-1];
			end
		end
	end

	// s1..s6: cofactors and determinant
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NE; k++) m_s1[k] <= $signed(s_tdata[k*EW +: EW]);
		end
		if (en[2]) begin
			for (int k = 0; k < NE; k++) begin
				pa_s2[k] <= PW'(m_s1[PA[k]] * m_s1[PB[k]]);
				pc_s2[k] <= PW'(m_s1[PC[k]] * m_s1[PD[k]]);
			end
			for (int j = 0; j < 3; j++) mr_s2[j] <= m_s1[j];
		end
		if (en[3]) begin
			for (int k = 0; k < NE; k++) adj_s3[k] <= pa_s2[k] - pc_s2[k];
			mr_s3 <= mr_s2;
		end
		if (en[4]) begin
			// split each cofactor of the first column into signed high and unsigned low halves
			for (int j = 0; j < 3; j++) begin
				ph_s4[j] <= PW'(mr_s3[j] * $signed(adj_s3[3*j][PW-1:EW]));
				pl_s4[j] <= (PW+1)'($signed({mr_s3[j][EW-1], mr_s3[j]})
					* $signed({1'b0, adj_s3[3*j][EW-1:0]}));
			end
			adj_s4 <= adj_s3;
		end
		if (en[5]) begin
			for (int j = 0; j < 3; j++) begin
				t_s5[j] <= $signed({ph_s4[j][PW-1], ph_s4[j], {EW{1'b0}}})
					+ $signed({{(DETW-PW-1){pl_s4[j][PW]}}, pl_s4[j]});
			end
			adj_s5 <= adj_s4;
		end
		if (en[6]) begin
			det_s6 <= t_s5[0] + t_s5[1] + t_s5[2];
			adj_s6 <= adj_s5;
		end
	end

	// s7: magnitudes, signs and numerator split
	always_ff @(posedge clk) begin
		logic [PW-1:0] mag;
		logic [XW-1:0] wide;
		logic [DETW-1:0] dm;
		if (en[7]) begin
			dm = det_s6[DETW-1] ? DETW'(-det_s6) : DETW'(det_s6);
			dmag_s7 <= dm[RW-1:0];
			sing_s7 <= (det_s6 == '0);
			for (int k = 0; k < NE; k++) begin
				mag = adj_s6[k][PW-1] ? PW'(-adj_s6[k]) : PW'(adj_s6[k]);
				wide = {{(XW-PW){1'b0}}, mag} << (2 * FRAC_BITS);
				rem_s7[k] <= wide[XW-1:QB];
				nlo_s7[k] <= wide[QB-1:0];
				neg_s7[k] <= adj_s6[k][PW-1] ^ det_s6[DETW-1];
			end
		end
	end

	// overflow check: quotient would need more than QB bits
	always_ff @(posedge clk) begin
		if (en[DIV0]) begin
			for (int k = 0; k < NE; k++) begin
				ovf_d[0][k] <= (rem_s7[k] >= dmag_s7);
				rem_d[0][k] <= rem_s7[k];
				nlo_d[0][k] <= nlo_s7[k];
				q_d[0][k]   <= '0;
			end
			neg_d[0]  <= neg_s7;
			dmag_d[0] <= dmag_s7;
			sing_d[0] <= sing_s7;
		end
	end

	// one restoring step per stage, nine lanes side by side
	for (genvar g = 0; g < QB; g++) begin : g_div
		always_ff @(posedge clk) begin
			logic [RW:0] rsh;
			logic [RW:0] diff;
			logic        ge;
			if (en[DIV0+1+g]) begin
				for (int k = 0; k < NE; k++) begin
					rsh  = {rem_d[g][k], nlo_d[g][k][QB-1]};
					diff = rsh - {1'b0, dmag_d[g]};
					ge   = (rsh >= {1'b0, dmag_d[g]});
					rem_d[g+1][k] <= ge ? diff[RW-1:0] : rsh[RW-1:0];
					nlo_d[g+1][k] <= {nlo_d[g][k][QB-2:0], 1'b0};
					q_d[g+1][k]   <= {q_d[g][k][QB-2:0], ge};
				end
				neg_d[g+1]  <= neg_d[g];
				ovf_d[g+1]  <= ovf_d[g];
				dmag_d[g+1] <= dmag_d[g];
				sing_d[g+1] <= sing_d[g];
			end
		end
	end

	// sign and saturate; a singular word gives all-zero entries
	always_ff @(posedge clk) begin
		logic [QB-1:0] q;
		if (en[LAST]) begin
			for (int k = 0; k < NE; k++) begin
				q = q_d[QB][k];
				if (sing_d[QB]) begin
					res_q[k*EW +: EW] <= '0;
				end else if (neg_d[QB][k]) begin
					if (ovf_d[QB][k] || q > NEG_MAX) res_q[k*EW +: EW] <= NEG_MAX;
					else res_q[k*EW +: EW] <= EW'(-q);
				end else begin
					if (ovf_d[QB][k] || q[QB-1]) res_q[k*EW +: EW] <= POS_MAX;
					else res_q[k*EW +: EW] <= q;
				end
			end
			sing_q <= sing_d[QB];
		end
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("singular word carries nonzero entries");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage is empty");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v[1])
		else $error("accepted word not captured in first stage");
endmodule

@@ tb/tb_matrix_inverse_3x3_core.sv @@
// Testbench for matrix_inverse_3x3_core: drives matrices over the input stream,
// predicts each inverse and singular flag, and checks every output word in order.
// Depends on mi3_pkg and the RTL of the core.
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3_core;
	import mi3_pkg::*;

	typedef logic signed [EW-1:0] entry_t;
	typedef struct {
		logic [OUT_W-1:0] inv;
		logic             singular;
	} inverse_t;
	typedef struct {
		logic [IN_W-1:0] mat;
		logic            has_exp;   // typed-in expectation present
		logic [OUT_W-1:0] inv;
		logic            singular;
	} row_t;

	localparam int N_RANDOM    = 1530;
	localparam int CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	inverse_t pending_q[$];
	int       mismatches;
	int       cycles;
	int       stall_cnt;

	matrix_inverse_3x3_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Exact inverse: cofactors, determinant, truncating division, saturation.
	function automatic inverse_t invert_matrix(logic [IN_W-1:0] mat);
		logic signed [EW-1:0]    m [NE];
		logic signed [PW:0]      cof [NE];
		logic signed [DETW+1:0]  det;
		logic [DETW+1:0]         dmag;
		logic [PW+2*FRAC_BITS:0] num;
		logic [PW+2*FRAC_BITS:0] quo;
		logic                    neg;
		inverse_t                res;
		for (int k = 0; k < NE; k++) m[k] = mat[k*EW +: EW];
		cof[0] = m[4]*m[8] - m[5]*m[7];
		cof[1] = m[2]*m[7] - m[1]*m[8];
		cof[2] = m[1]*m[5] - m[2]*m[4];
		cof[3] = m[5]*m[6] - m[3]*m[8];
		cof[4] = m[0]*m[8] - m[2]*m[6];
		cof[5] = m[2]*m[3] - m[0]*m[5];
		cof[6] = m[3]*m[7] - m[4]*m[6];
		cof[7] = m[1]*m[6] - m[0]*m[7];
		cof[8] = m[0]*m[4] - m[1]*m[3];
		det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
		res.inv = '0;
		res.singular = (det == 0);
		if (!res.singular) begin
			dmag = det < 0 ? -det : det;
			for (int k = 0; k < NE; k++) begin
				if (cof[k] != 0) begin
					num = (cof[k] < 0 ? -cof[k] : cof[k]);
					num = num << (2*FRAC_BITS);
					quo = num / dmag;
					neg = (cof[k] < 0) != (det < 0);
					if (neg)
						res.inv[k*EW +: EW] = quo > 33'h80000000 ? NEG_MAX : -quo[EW-1:0];
					else
						res.inv[k*EW +: EW] = quo > 32'h7FFFFFFF ? POS_MAX : quo[EW-1:0];
				end
			end
		end
		return res;
	endfunction

	function automatic logic [IN_W-1:0] pack9(entry_t e0, entry_t e1, entry_t e2,
			entry_t e3, entry_t e4, entry_t e5, entry_t e6, entry_t e7, entry_t e8);
		return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
	endfunction

	function automatic entry_t rand_entry();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8)) - 4;
			2: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
			3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			default: return ($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rand_matrix();
		logic [IN_W-1:0] mat;
		int              r;
		for (int k = 0; k < NE; k++) mat[k*EW +: EW] = rand_entry();
		// force some singular matrices: copy or zero a row
		r = $urandom_range(0, 9);
		if (r == 0) mat[3*EW +: 3*EW] = mat[0 +: 3*EW];
		else if (r == 1) mat[6*EW +: 3*EW] = '0;
		return mat;
	endfunction

	// Leaves s_tvalid high after the accepting edge; drop it before idling.
	task automatic send_word(logic [IN_W-1:0] mat);
		int gap;
		gap = $urandom_range(0, 9) < 6 ? 0 :
			($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		pending_q.push_back(invert_matrix(mat));
		do @(posedge clk); while (!s_tready);
	endtask

	// Output side: random stalls, compare with the oldest prediction.
	always @(posedge clk) begin
		inverse_t exp_w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output word %h singular %b", m_tdata, m_tuser);
				end else begin
					exp_w = pending_q.pop_front();
					for (int k = 0; k < NE; k++)
						if (m_tdata[k*EW +: EW] !== exp_w.inv[k*EW +: EW]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("r%0d%0d: expected %h got %h", k/3, k%3,
									exp_w.inv[k*EW +: EW], m_tdata[k*EW +: EW]);
						end
					if (m_tuser !== exp_w.singular) begin
						mismatches++;
						if (mismatches <= 10)
							$display("singular: expected %b got %b", exp_w.singular, m_tuser);
					end
				end
			end
			// mostly short stalls, now and then a long one
			if (stall_cnt != 0) begin
				stall_cnt--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 199) == 0) begin
				stall_cnt = $urandom_range(10, 60);
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("matrix_inverse_3x3_core test failed");
			$finish;
		end
	end

	initial begin
		localparam entry_t ONE = 32'sh10000;
		row_t dir_rows[$];
		row_t rw;
		inverse_t pred;
		logic [OUT_W-1:0] idn;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		mismatches = 0;
		cycles     = 0;
		stall_cnt  = 0;
		idn = '0;
		idn[0 +: EW] = ONE;
		idn[4*EW +: EW] = ONE;
		idn[8*EW +: EW] = ONE;
		// zero matrix: singular
		dir_rows.push_back('{'0, 1'b1, '0, 1'b1});
		// identity
		dir_rows.push_back('{pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, idn, 1'b0});
		// all-ones matrix: singular
		dir_rows.push_back('{pack9(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1'b1, '0, 1'b1});
		// all -2^31: singular
		dir_rows.push_back('{{NE{NEG_MAX}}, 1'b1, '0, 1'b1});
		// predictor rows: extremes, tiny diagonal (saturates), zero cofactors
		dir_rows.push_back('{pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(-1, 0, 0, 0, 1, 0, 0, 0, -1), 1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(POS_MAX, 0, 0, 0, POS_MAX, 0, 0, 0, POS_MAX),
			1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(NEG_MAX, 0, 0, 0, NEG_MAX, 0, 0, 0, NEG_MAX),
			1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(NEG_MAX, POS_MAX, 1, -1, NEG_MAX, POS_MAX, 0, -1, NEG_MAX),
			1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE),
			1'b0, '0, 1'b0});
		dir_rows.push_back('{{NE{32'hFFFFFFFF}}, 1'b0, '0, 1'b0});
		dir_rows.push_back('{{NE{32'h55555555}} ^ {3{96'hFFFF0000_00000000_0000FFFF}},
			1'b0, '0, 1'b0});
		dir_rows.push_back('{pack9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 1'b0, '0, 1'b0});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			pred = invert_matrix(rw.mat);
			if (rw.has_exp && (pred.inv !== rw.inv || pred.singular !== rw.singular)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: predictor disagrees with typed value", i);
			end
			send_word(rw.mat);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// hold off until the pipeline has drained
				s_tvalid <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
			end
			send_word(rand_matrix());
		end
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("matrix_inverse_3x3_core test passed");
		else
			$display("matrix_inverse_3x3_core test failed");
		$finish;
	end
endmodule
